@@ src/ptts_pkg.sv @@
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  localparam int MAX_TASKS = 8;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int ID_W      = 3;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic [15:0]     period;
    logic [15:0]     remaining;
    logic [7:0]      priority_val;
    logic [ID_W-1:0] slot;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_TICK
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   new_entry;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

endpackage

@@ src/ptts_if.sv @@
// ----------------------------------------------------------------------------
// ptts_in_if / ptts_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface ptts_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] period;
  logic [15:0] initial_delay;
  logic [7:0]  priority_req;

  modport source (output valid, kind, period, initial_delay, priority_req, input ready);
  modport sink   (input valid, kind, period, initial_delay, priority_req, output ready);
endinterface

interface ptts_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       fired;
  logic [2:0] task_id;
  logic       last;

  modport source (output valid, accepted, fired, task_id, last, input ready);
  modport sink   (input valid, accepted, fired, task_id, last, output ready);
endinterface

@@ src/periodic_task_tick_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top
// Periodic task table kept as a row of cells in priority order.
// ----------------------------------------------------------------------------
// An add word is stored while the row of cells shifts open a slot; its result
// word is registered and offered in the cycle after. A tick word counts down
// every stored entry at once, then a scan pointer visits the stored entries one
// per cycle and holds on each due entry until its result word is taken. Input
// is taken only while no word is in flight.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_top (
  input  logic       clk,
  input  logic       rst_n,
  ptts_in_if.sink    in_ch,
  ptts_out_if.source out_ch
);
  import ptts_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic             out_acc_r, out_fired_r, out_last_r;
  logic [ID_W-1:0]  out_id_r;

  cell_ctl_t        ctl;
  logic             in_fire, out_fire, full;
  logic [MAX_TASKS-1:0] valid_vec, ahead_vec, due_vec, above_vec;
  entry_t           entry_vec [MAX_TASKS];
  logic             scan_end, cur_due, more_due;
  logic [31:0]      count_wide;

  assign full       = (count_r == CNT_W'(MAX_TASKS));
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_fire   = out_ch.valid && out_ch.ready;
  assign count_wide = 32'(count_r);
  assign scan_end   = (idx_r >= count_r);
  assign cur_due    = due_vec[idx_r[IDX_W-1:0]];
  assign more_due   = |(due_vec & above_vec);

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      valid_vec[i] = (32'(i) < count_wide);
      above_vec[i] = (32'(i) > 32'(idx_r)) && valid_vec[i];
    end
  end

  always_comb begin
    ctl.new_entry.period       = (in_ch.period == 16'd0) ? 16'd1 : in_ch.period;
    ctl.new_entry.remaining    = (in_ch.initial_delay == 16'd0) ? 16'd1
                                                                : in_ch.initial_delay;
    ctl.new_entry.priority_val = in_ch.priority_req;
    ctl.new_entry.slot         = count_wide[ID_W-1:0];
    ctl.op                     = CELL_HOLD;
    if (in_fire) begin
      if (in_ch.kind == KIND_TICK) begin
        ctl.op = CELL_TICK;
      end else if (!full) begin
        ctl.op = CELL_INSERT;
      end
    end
  end

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    if (g == 0) begin : g_head
      ptts_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .valid_i    (valid_vec[g]),
        .left_ahead (1'b1),
        .left_entry (ctl.new_entry),
        .ahead      (ahead_vec[g]),
        .entry      (entry_vec[g]),
        .due        (due_vec[g])
      );
    end else begin : g_body
      ptts_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .valid_i    (valid_vec[g]),
        .left_ahead (ahead_vec[g-1]),
        .left_entry (entry_vec[g-1]),
        .ahead      (ahead_vec[g]),
        .entry      (entry_vec[g]),
        .due        (due_vec[g])
      );
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.kind == KIND_TICK) ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        if (scan_end || cur_due) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          state_nxt = out_last_r ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_IDLE: in_ch.ready  = 1'b1;
      ST_OUT:  out_ch.valid = 1'b1;
      default: begin
      end
    endcase
  end

  assign out_ch.accepted = out_acc_r;
  assign out_ch.fired    = out_fired_r;
  assign out_ch.task_id  = out_id_r;
  assign out_ch.last     = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.op == CELL_INSERT) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (ctl.op == CELL_TICK) begin
        idx_r <= '0;
      end else if (state_r == ST_SCAN && !scan_end && !cur_due) begin
        idx_r <= idx_r + CNT_W'(1);
      end else if (state_r == ST_OUT && out_fire && !out_last_r) begin
        idx_r <= idx_r + CNT_W'(1);
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire && in_ch.kind == KIND_ADD) begin
      out_acc_r   <= !full;
      out_fired_r <= 1'b0;
      out_id_r    <= full ? '0 : count_wide[ID_W-1:0];
      out_last_r  <= 1'b1;
    end else if (state_r == ST_SCAN) begin
      if (scan_end) begin
        out_acc_r   <= 1'b0;
        out_fired_r <= 1'b0;
        out_id_r    <= '0;
        out_last_r  <= 1'b1;
      end else if (cur_due) begin
        out_acc_r   <= 1'b0;
        out_fired_r <= 1'b1;
        out_id_r    <= entry_vec[idx_r[IDX_W-1:0]].slot;
        out_last_r  <= !more_due;
      end
    end
  end

endmodule

@@ src/ptts_cell.sv @@
// ----------------------------------------------------------------------------
// ptts_cell
// One table entry: insert in priority order by shifting from its left
// neighbor, and count down on a tick.
// ----------------------------------------------------------------------------
module ptts_cell (
  input  logic               clk,
  input  ptts_pkg::cell_ctl_t ctl,
  input  logic               valid_i,
  input  logic               left_ahead,
  input  ptts_pkg::entry_t   left_entry,
  output logic               ahead,
  output ptts_pkg::entry_t   entry,
  output logic               due
);
  import ptts_pkg::*;

  entry_t      entry_r, entry_nxt;
  logic        due_r, due_nxt;
  logic [15:0] dec;

  assign entry = entry_r;
  assign due   = due_r;
  assign ahead = valid_i && (entry_r.priority_val <= ctl.new_entry.priority_val);
  assign dec   = entry_r.remaining - 16'd1;

  always_comb begin
    entry_nxt = entry_r;
    due_nxt   = due_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (!ahead) begin
          entry_nxt = left_ahead ? ctl.new_entry : left_entry;
        end
      end
      CELL_TICK: begin
        due_nxt = 1'b0;
        if (valid_i) begin
          if (dec == 16'd0) begin
            entry_nxt.remaining = entry_r.period;
            due_nxt             = 1'b1;
          end else begin
            entry_nxt.remaining = dec;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    due_r   <= due_nxt;
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
// Add and tick words go into the input channel with random gaps. A model of
// the priority-ordered task table predicts the result words of each accepted
// word. The monitor compares every result word with the oldest prediction.
// A short table of directed words covers the empty tick, zero and maximum
// period and delay, both priority extremes and priority ties. A random run
// follows, mostly ticks, that fills the table and then keeps hitting the
// full-table reject. The bench also tests one long output stall that backs
// up the input, and one pause that lets all results drain.
// ----------------------------------------------------------------------------
module tb_top;
  import ptts_pkg::*;

  localparam int RANDOM_WORDS   = 300;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 2 * MAX_TASKS + 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic       accepted;
    logic       fired;
    logic [2:0] task_id;
    logic       last;
  } sched_result_t;

  typedef struct packed {
    logic          kind;
    logic [15:0]   period;
    logic [15:0]   delay;
    logic [7:0]    prio;
    logic          typed;
    sched_result_t res;
  } stim_row_t;

  localparam int N_ROWS = 15;
  localparam stim_row_t PLAN [N_ROWS] = '{
    '{KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b1}},
    '{KIND_ADD,  16'h0000, 16'h0000, 8'h80, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b1}},
    '{KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, '{1'b0, 1'b0, 3'd0, 1'b0}},
    '{KIND_ADD,  16'hffff, 16'hffff, 8'hff, 1'b1, '{1'b1, 1'b0, 3'd1, 1'b1}},
    '{KIND_ADD,  16'h0003, 16'h0002, 8'h00, 1'b1, '{1'b1, 1'b0, 3'd2, 1'b1}},
    '{KIND_ADD,  16'h0002, 16'h0000, 8'h80, 1'b1, '{1'b1, 1'b0, 3'd3, 1'b1}},
    '{KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, '{1'b0, 1'b0, 3'd0, 1'b0}},
    '{KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, '{1'b0, 1'b0, 3'd0, 1'b0}},
    '{KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, '{1'b0, 1'b0, 3'd0, 1'b0}},
    '{KIND_ADD,  16'h0005, 16'h0001, 8'h00, 1'b1, '{1'b1, 1'b0, 3'd4, 1'b1}},
    '{KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, '{1'b0, 1'b0, 3'd0, 1'b0}},
    '{KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, '{1'b0, 1'b0, 3'd0, 1'b0}},
    '{KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, '{1'b0, 1'b0, 3'd0, 1'b0}},
    '{KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, '{1'b0, 1'b0, 3'd0, 1'b0}},
    '{KIND_TICK, 16'h0000, 16'h0000, 8'h00, 1'b0, '{1'b0, 1'b0, 3'd0, 1'b0}}
  };

  logic clk;
  logic rst_n;

  ptts_in_if  in_ch ();
  ptts_out_if out_ch ();

  periodic_task_tick_scheduler_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  entry_t        task_tbl [MAX_TASKS];
  int unsigned   task_cnt;
  sched_result_t step_results [$];
  sched_result_t pending_results [$];

  int unsigned errors;
  int unsigned results_checked;
  int unsigned adds_sent;
  int unsigned ticks_sent;
  int unsigned fires_seen;
  int unsigned rejects_seen;
  int unsigned idle_cycles;
  bit          no_idle;
  bit          hold_results;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [15:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 85) return 16'($urandom_range(1, 8));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic predict_schedule(input logic kind, input logic [15:0] per,
                                  input logic [15:0] dly, input logic [7:0] pri);
    int unsigned   pos;
    int unsigned   n_due;
    sched_result_t r;
    step_results.delete();
    if (kind == KIND_ADD) begin
      if (task_cnt >= MAX_TASKS) begin
        step_results.push_back('{1'b0, 1'b0, 3'd0, 1'b1});
      end else begin
        pos = 0;
        while (pos < task_cnt && task_tbl[pos].priority_val <= pri) pos++;
        for (int m = task_cnt; m > pos; m--) task_tbl[m] = task_tbl[m-1];
        task_tbl[pos].period       = (per == 16'd0) ? 16'd1 : per;
        task_tbl[pos].remaining    = (dly == 16'd0) ? 16'd1 : dly;
        task_tbl[pos].priority_val = pri;
        task_tbl[pos].slot         = ID_W'(task_cnt);
        step_results.push_back('{1'b1, 1'b0, ID_W'(task_cnt), 1'b1});
        task_cnt++;
      end
    end else begin
      n_due = 0;
      for (int i = 0; i < task_cnt; i++) begin
        task_tbl[i].remaining = task_tbl[i].remaining - 16'd1;
        if (task_tbl[i].remaining == 16'd0) begin
          task_tbl[i].remaining = task_tbl[i].period;
          if (n_due < MAX_TASKS) begin
            step_results.push_back('{1'b0, 1'b1, task_tbl[i].slot, 1'b0});
            n_due++;
          end
        end
      end
      if (n_due == 0) begin
        step_results.push_back('{1'b0, 1'b0, 3'd0, 1'b1});
      end else begin
        r = step_results.pop_back();
        r.last = 1'b1;
        step_results.push_back(r);
      end
    end
  endtask

  task automatic send_word(input logic kind, input logic [15:0] per,
                           input logic [15:0] dly, input logic [7:0] pri);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.kind          <= kind;
    in_ch.period        <= per;
    in_ch.initial_delay <= dly;
    in_ch.priority_req  <= pri;
    in_ch.valid         <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (kind == KIND_ADD) adds_sent++;
    else ticks_sent++;
  endtask

  // output side: random stalls, one long hold on request
  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results = 1'b0;
      end
      gap = no_idle ? 0 : pick_gap();
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    sched_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_ch.fired) fires_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("tb: unexpected word acc=%0b fired=%0b id=%0d last=%0b",
                   out_ch.accepted, out_ch.fired, out_ch.task_id, out_ch.last);
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (out_ch.accepted !== exp_res.accepted || out_ch.fired !== exp_res.fired ||
            out_ch.task_id !== exp_res.task_id || out_ch.last !== exp_res.last) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("tb: mismatch exp acc=%0b fired=%0b id=%0d last=%0b, got acc=%0b fired=%0b id=%0d last=%0b",
                     exp_res.accepted, exp_res.fired, exp_res.task_id, exp_res.last,
                     out_ch.accepted, out_ch.fired, out_ch.task_id, out_ch.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired, %0d results outstanding", pending_results.size());
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic        kind;
    logic [15:0] per;
    logic [15:0] dly;
    logic [7:0]  pri;
    int unsigned r;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_TICK;
    in_ch.period        <= 16'd0;
    in_ch.initial_delay <= 16'd0;
    in_ch.priority_req  <= 8'd0;
    task_cnt        = 0;
    errors          = 0;
    results_checked = 0;
    adds_sent       = 0;
    ticks_sent      = 0;
    fires_seen      = 0;
    rejects_seen    = 0;
    idle_cycles     = 0;
    no_idle         = 1'b0;
    hold_results    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      send_word(PLAN[i].kind, PLAN[i].period, PLAN[i].delay, PLAN[i].prio);
      predict_schedule(PLAN[i].kind, PLAN[i].period, PLAN[i].delay, PLAN[i].prio);
      if (PLAN[i].typed) pending_results.push_back(PLAN[i].res);
      else foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 60) hold_results = 1'b1;
      if (i == 150) begin
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      no_idle = (i >= 200 && i < 240);
      r = $urandom_range(0, 99);
      if ((task_cnt < MAX_TASKS && r < 12) || (task_cnt >= MAX_TASKS && r < 6)) begin
        kind = KIND_ADD;
        if (task_cnt >= MAX_TASKS) rejects_seen++;
      end else begin
        kind = KIND_TICK;
      end
      per = pick_count();
      dly = pick_count();
      pri = 8'($urandom_range(0, 255));
      send_word(kind, per, dly, pri);
      predict_schedule(kind, per, dly, pri);
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d adds (%0d on a full table), %0d ticks, %0d tasks stored",
             adds_sent, rejects_seen, ticks_sent, task_cnt);
    $display("tb: %0d result words checked, %0d task firings, %0d errors",
             results_checked, fires_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ periodic_task_tick_scheduler_top.f @@
src/ptts_pkg.sv
src/ptts_if.sv
src/ptts_cell.sv
src/periodic_task_tick_scheduler_top.sv
sim/tb_top.sv
